>>> design/rgb_to_hsv_converter_assert.svh
// assertion macros shared by the rgb to hsv converter checkers
// no dependencies
`ifndef RGB_TO_HSV_CONVERTER_ASSERT_SVH
`define RGB_TO_HSV_CONVERTER_ASSERT_SVH

// same-cycle implication, disabled while reset is asserted
`define RHSV_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define RHSV_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/rhsv_pkg.sv
// shared types and constants for the rgb to hsv converter
// no dependencies
`timescale 1ns / 1ps

package rhsv_pkg;

    localparam int PIX_W     = 8;
    localparam int DIV_STEPS = 8;

    localparam logic [PIX_W-1:0] FULL_SCALE  = 8'd255;
    localparam logic [PIX_W-1:0] SECTOR_SPAN = 8'd43;
    localparam logic [PIX_W-1:0] BASE_RED    = 8'd0;
    localparam logic [PIX_W-1:0] BASE_GREEN  = 8'd85;
    localparam logic [PIX_W-1:0] BASE_BLUE   = 8'd171;

    typedef enum logic [1:0] {
        SECTOR_RED,
        SECTOR_GREEN,
        SECTOR_BLUE
    } sector_t;

    typedef struct packed {
        logic [PIX_W-1:0] brightness;
        sector_t          sector;
        logic             neg;
        logic             black;
        logic             grey;
    } pix_info_t;

    typedef struct packed {
        pix_info_t        info;
        logic [PIX_W-1:0] chroma;
        logic [PIX_W-1:0] mag;
    } front_item_t;

    typedef struct packed {
        logic [PIX_W-1:0] rem;
        logic [PIX_W-1:0] quo;
        logic [PIX_W-1:0] div;
    } div_lane_t;

    typedef struct packed {
        pix_info_t info;
        div_lane_t sat;
        div_lane_t hue;
    } div_item_t;

endpackage

>>> design/rhsv_rgb_if.sv
// input pixel channel of the rgb to hsv converter
// depends on rhsv_pkg
`timescale 1ns / 1ps

interface rhsv_rgb_if;
    logic                      valid;
    logic                      ready;
    logic [rhsv_pkg::PIX_W-1:0] red;
    logic [rhsv_pkg::PIX_W-1:0] green;
    logic [rhsv_pkg::PIX_W-1:0] blue;

    modport source (output valid, red, green, blue, input ready);
    modport sink   (input valid, red, green, blue, output ready);
endinterface

>>> design/rhsv_hsv_if.sv
// result pixel channel of the rgb to hsv converter
// depends on rhsv_pkg
`timescale 1ns / 1ps

interface rhsv_hsv_if;
    logic                      valid;
    logic                      ready;
    logic [rhsv_pkg::PIX_W-1:0] hue;
    logic [rhsv_pkg::PIX_W-1:0] saturation;
    logic [rhsv_pkg::PIX_W-1:0] brightness;

    modport source (output valid, hue, saturation, brightness, input ready);
    modport sink   (input valid, hue, saturation, brightness, output ready);
endinterface

>>> design/rgb_to_hsv_converter.sv
// a pixel passes through the two front registers, the divider registers and the output register in that order
// throughput: one pixel per clock while ready is high; two front stages, eight radix-2 divider
// stages for saturation and hue side by side, one output stage
// ready drops only while the output register and its skid entry both hold results
// reset clears the valid bits of every stage; payload registers are not reset
// depends on rhsv_pkg, rhsv_rgb_if, rhsv_hsv_if, rhsv_front, rhsv_div_stage, rhsv_back
`timescale 1ns / 1ps

module rgb_to_hsv_converter (
    input  logic       clk,
    input  logic       rst_n,
    rhsv_rgb_if.sink   pixel_in,
    rhsv_hsv_if.source pixel_out
);

    logic                en;
    logic                div_valid [0:rhsv_pkg::DIV_STEPS];
    rhsv_pkg::div_item_t div_item  [0:rhsv_pkg::DIV_STEPS];

    rhsv_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .pixel_in  (pixel_in),
        .valid_out (div_valid[0]),
        .item_out  (div_item[0])
    );

    for (genvar i = 0; i < rhsv_pkg::DIV_STEPS; i++)
    begin : g_div
        rhsv_div_stage u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .valid_in  (div_valid[i]),
            .item_in   (div_item[i]),
            .valid_out (div_valid[i+1]),
            .item_out  (div_item[i+1])
        );
    end

    rhsv_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (div_valid[rhsv_pkg::DIV_STEPS]),
        .item_in   (div_item[rhsv_pkg::DIV_STEPS]),
        .en        (en),
        .pixel_out (pixel_out)
    );

endmodule

>>> design/rhsv_front.sv
// front stages: max/min, sector select, then the divider operands
// depends on rhsv_pkg and rhsv_rgb_if
`timescale 1ns / 1ps

module rhsv_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    rhsv_rgb_if.sink         pixel_in,
    output logic             valid_out,
    output rhsv_pkg::div_item_t item_out
);

    logic [rhsv_pkg::PIX_W-1:0] r;
    logic [rhsv_pkg::PIX_W-1:0] g;
    logic [rhsv_pkg::PIX_W-1:0] b;
    logic [rhsv_pkg::PIX_W-1:0] mn;
    logic [rhsv_pkg::PIX_W-1:0] op_a;
    logic [rhsv_pkg::PIX_W-1:0] op_b;
    rhsv_pkg::front_item_t      a_next;
    rhsv_pkg::front_item_t      a_reg;
    logic                       a_valid_reg;
    logic [2*rhsv_pkg::PIX_W-1:0] sat_num;
    logic [2*rhsv_pkg::PIX_W-1:0] hue_num;
    rhsv_pkg::div_item_t        b_next;
    rhsv_pkg::div_item_t        b_reg;
    logic                       b_valid_reg;

    assign pixel_in.ready = en;
    assign r = pixel_in.red;
    assign g = pixel_in.green;
    assign b = pixel_in.blue;

    // stage a: largest channel, sector and signed difference
    always_comb
    begin
        a_next = '0;
        if (r >= g && r >= b)
        begin
            a_next.info.sector     = rhsv_pkg::SECTOR_RED;
            a_next.info.brightness = r;
            op_a = g;
            op_b = b;
        end
        else if (g >= b)
        begin
            a_next.info.sector     = rhsv_pkg::SECTOR_GREEN;
            a_next.info.brightness = g;
            op_a = b;
            op_b = r;
        end
        else
        begin
            a_next.info.sector     = rhsv_pkg::SECTOR_BLUE;
            a_next.info.brightness = b;
            op_a = r;
            op_b = g;
        end
        mn = r;
        if (g < mn)
        begin
            mn = g;
        end
        if (b < mn)
        begin
            mn = b;
        end
        a_next.chroma     = a_next.info.brightness - mn;
        a_next.info.neg   = op_a < op_b;
        a_next.mag        = a_next.info.neg ? (op_b - op_a) : (op_a - op_b);
        a_next.info.black = a_next.info.brightness == '0;
        a_next.info.grey  = a_next.chroma == '0;
    end

    // stage b: scaled numerators for both quotients
    always_comb
    begin
        sat_num = {a_reg.chroma, rhsv_pkg::PIX_W'(0)}
                - {rhsv_pkg::PIX_W'(0), a_reg.chroma};
        hue_num = {rhsv_pkg::PIX_W'(0), a_reg.mag}
                * {rhsv_pkg::PIX_W'(0), rhsv_pkg::SECTOR_SPAN};
        b_next.info     = a_reg.info;
        b_next.sat.rem  = sat_num[2*rhsv_pkg::PIX_W-1:rhsv_pkg::PIX_W];
        b_next.sat.quo  = sat_num[rhsv_pkg::PIX_W-1:0];
        b_next.sat.div  = a_reg.info.brightness;
        b_next.hue.rem  = hue_num[2*rhsv_pkg::PIX_W-1:rhsv_pkg::PIX_W];
        b_next.hue.quo  = hue_num[rhsv_pkg::PIX_W-1:0];
        b_next.hue.div  = a_reg.chroma;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg <= pixel_in.valid;
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_reg <= a_next;
            b_reg <= b_next;
        end
    end

    assign valid_out = b_valid_reg;
    assign item_out  = b_reg;

endmodule

>>> design/rhsv_div_stage.sv
// one restoring division step for the saturation and hue lanes
// depends on rhsv_pkg
`timescale 1ns / 1ps

module rhsv_div_stage (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                valid_in,
    input  rhsv_pkg::div_item_t item_in,
    output logic                valid_out,
    output rhsv_pkg::div_item_t item_out
);

    logic [rhsv_pkg::PIX_W:0] sat_trial;
    logic [rhsv_pkg::PIX_W:0] hue_trial;
    logic                     sat_take;
    logic                     hue_take;
    rhsv_pkg::div_item_t      item_next;
    rhsv_pkg::div_item_t      item_reg;
    logic                     valid_reg;

    always_comb
    begin
        item_next      = item_in;
        sat_trial      = {item_in.sat.rem, item_in.sat.quo[rhsv_pkg::PIX_W-1]};
        hue_trial      = {item_in.hue.rem, item_in.hue.quo[rhsv_pkg::PIX_W-1]};
        sat_take       = sat_trial >= {1'b0, item_in.sat.div};
        hue_take       = hue_trial >= {1'b0, item_in.hue.div};
        item_next.sat.rem = sat_take ?
            rhsv_pkg::PIX_W'(sat_trial - {1'b0, item_in.sat.div}) :
            sat_trial[rhsv_pkg::PIX_W-1:0];
        item_next.hue.rem = hue_take ?
            rhsv_pkg::PIX_W'(hue_trial - {1'b0, item_in.hue.div}) :
            hue_trial[rhsv_pkg::PIX_W-1:0];
        item_next.sat.quo = {item_in.sat.quo[rhsv_pkg::PIX_W-2:0], sat_take};
        item_next.hue.quo = {item_in.hue.quo[rhsv_pkg::PIX_W-2:0], hue_take};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            item_reg <= item_next;
        end
    end

    assign valid_out = valid_reg;
    assign item_out  = item_reg;

endmodule

>>> design/rhsv_back.sv
// hue offset, special cases, output register and skid entry
// depends on rhsv_pkg and rhsv_hsv_if
`timescale 1ns / 1ps

module rhsv_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                valid_in,
    input  rhsv_pkg::div_item_t item_in,
    output logic                en,
    rhsv_hsv_if.source          pixel_out
);

    localparam int RES_W = 3 * rhsv_pkg::PIX_W;

    logic [rhsv_pkg::PIX_W-1:0] base;
    logic [rhsv_pkg::PIX_W-1:0] hue_val;
    logic [rhsv_pkg::PIX_W-1:0] sat_val;
    logic [RES_W-1:0]           result;
    logic [RES_W-1:0]           out_next;
    logic [RES_W-1:0]           out_reg;
    logic [RES_W-1:0]           skid_next;
    logic [RES_W-1:0]           skid_reg;
    logic                       out_valid_next;
    logic                       out_valid_reg;
    logic                       skid_valid_next;
    logic                       skid_valid_reg;
    logic                       take_out;
    logic                       load;

    always_comb
    begin
        case (item_in.info.sector)
            rhsv_pkg::SECTOR_RED:   base = rhsv_pkg::BASE_RED;
            rhsv_pkg::SECTOR_GREEN: base = rhsv_pkg::BASE_GREEN;
            rhsv_pkg::SECTOR_BLUE:  base = rhsv_pkg::BASE_BLUE;
            default:                base = rhsv_pkg::BASE_RED;
        endcase
        if (item_in.info.grey)
        begin
            hue_val = '0;
        end
        else if (item_in.info.neg)
        begin
            hue_val = base - item_in.hue.quo;
        end
        else
        begin
            hue_val = base + item_in.hue.quo;
        end
        sat_val = item_in.info.black ? '0 : item_in.sat.quo;
        result  = {hue_val, sat_val, item_in.info.brightness};
    end

    assign en       = !skid_valid_reg;
    assign take_out = out_valid_reg && pixel_out.ready;
    assign load     = valid_in && en;

    always_comb
    begin
        out_next        = out_reg;
        skid_next       = skid_reg;
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (skid_valid_reg)
        begin
            if (take_out)
            begin
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (load)
        begin
            if (!out_valid_reg || take_out)
            begin
                out_next       = result;
                out_valid_next = 1'b1;
            end
            else
            begin
                skid_next       = result;
                skid_valid_next = 1'b1;
            end
        end
        else if (take_out)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign pixel_out.valid      = out_valid_reg;
    assign pixel_out.hue        = out_reg[RES_W-1:2*rhsv_pkg::PIX_W];
    assign pixel_out.saturation = out_reg[2*rhsv_pkg::PIX_W-1:rhsv_pkg::PIX_W];
    assign pixel_out.brightness = out_reg[rhsv_pkg::PIX_W-1:0];

endmodule

>>> design/rhsv_checker.sv
// port-level checks for the rgb to hsv converter, bound to the top level
// depends on rgb_to_hsv_converter_assert.svh and rgb_to_hsv_converter
`timescale 1ns / 1ps
`include "rgb_to_hsv_converter_assert.svh"

module rhsv_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] hue,
    input logic [7:0] saturation,
    input logic [7:0] brightness
);

    // input stalls only behind a held result
    `RHSV_ASSERT_IMP(a_stall_needs_result, clk, rst_n, !in_ready, out_valid,
        "stall without result")
    `RHSV_ASSERT_IMP(a_stall_after_block, clk, rst_n, !in_ready,
        $past(out_valid && !out_ready), "stall without blocked transaction")
    `RHSV_ASSERT_IMP(a_grey_hue, clk, rst_n, out_valid && saturation == 8'd0,
        hue == 8'd0, "hue set on grey pixel")
    `RHSV_ASSERT_IMP(a_black_sat, clk, rst_n, out_valid && brightness == 8'd0,
        saturation == 8'd0, "saturation set on black pixel")
    `RHSV_ASSERT_NEXT(a_hold_result, clk, rst_n, out_valid && !out_ready,
        out_valid && $stable(hue) && $stable(saturation) && $stable(brightness),
        "stalled result changed")

endmodule

bind rgb_to_hsv_converter rhsv_checker u_rhsv_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ready   (pixel_in.ready),
    .out_valid  (pixel_out.valid),
    .out_ready  (pixel_out.ready),
    .hue        (pixel_out.hue),
    .saturation (pixel_out.saturation),
    .brightness (pixel_out.brightness)
);
